@@ hw/rtl/intfmt_pkg.sv @@
`default_nettype none

package intfmt_pkg;

    localparam int DEFAULT_MAX_DIGITS = 22;
    localparam int VALUE_W = 64;
    localparam int FIELD_MAX = 64;
    localparam int FIELD_W = 7;
    localparam int CHAR_W = 7;

    localparam logic [1:0] MODE_OCT = 2'd0;
    localparam logic [1:0] MODE_DEC = 2'd1;
    localparam logic [1:0] MODE_HEX = 2'd2;

    typedef enum logic [1:0] {
        SIGN_NONE,
        SIGN_PLUS,
        SIGN_BLANK,
        SIGN_MINUS
    } sign_code_t;

    localparam logic [CHAR_W-1:0] CH_BLANK = 7'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS = 7'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] CH_UPPER_X = 7'h58;
    localparam logic [CHAR_W-1:0] CH_LOWER_X = 7'h78;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] base_ch;
        begin
            base_ch = upper ? CH_UPPER_A : CH_LOWER_A;
            if (d < 4'd10)
            begin
                digit_char = CH_ZERO + {3'd0, d};
            end
            else
            begin
                digit_char = base_ch + {3'd0, d} - 7'd10;
            end
        end
    endfunction

    function automatic logic [CHAR_W-1:0] sign_glyph(input sign_code_t code);
        begin
            unique case (code)
                SIGN_PLUS:  sign_glyph = CH_PLUS;
                SIGN_BLANK: sign_glyph = CH_BLANK;
                SIGN_MINUS: sign_glyph = CH_MINUS;
                default:    sign_glyph = CH_BLANK;
            endcase
        end
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/integer_field_formatter.sv @@
// Integer field formatter: prints one 64-bit value as a padded ASCII field.
// Input items arrive on in_valid/in_ready with the value and its format flags;
// characters leave on out_valid/out_ready, with last set on the final
// character of the field. A field holds at most 64 characters.
// The cfg_wen/cfg_wdata port writes the truncate-to-32 mode; write it only
// while the block is idle.
// Decimal values go through a shift-and-add-3 converter, one value bit per
// cycle. Octal and hex digits load directly from the value. A digit register
// then shifts out leading zeros, keeping at least one digit. After that the
// sequencer emits one character per cycle while the receiver takes them.
// The leading pad, sign, prefix, zero pad and trailing pad steps are passed
// through even when they have nothing to print. The block accepts one item
// at a time; in_ready returns high in the cycle after the last character
// has been loaded into the output register.
// When the receiver stalls, the output register holds its character and the
// sequencer waits. Reset empties the output register, returns the sequencer
// to idle and clears the truncate mode.
`default_nettype none

module integer_field_formatter #(
    parameter int MAX_DIGITS = intfmt_pkg::DEFAULT_MAX_DIGITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wen,
    input  wire logic                            cfg_wdata,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [intfmt_pkg::VALUE_W-1:0]  value,
    input  wire logic [1:0]                      mode,
    input  wire logic                            uppercase,
    input  wire logic [1:0]                      sign_code,
    input  wire logic                            alt_form,
    input  wire logic                            left_adjust,
    input  wire logic                            zero_pad,
    input  wire logic [intfmt_pkg::FIELD_W-1:0]  width,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [intfmt_pkg::CHAR_W-1:0]        out_char,
    output logic                                 last
);

    localparam int DIG_BITS = 4 * MAX_DIGITS;
    localparam int NDIG_W = $clog2(MAX_DIGITS + 1);
    localparam int OCT_BITS = 3 * MAX_DIGITS;
    localparam int HEX_BITS = 4 * MAX_DIGITS;
    localparam int VW = intfmt_pkg::VALUE_W;
    localparam int FW = intfmt_pkg::FIELD_W;
    localparam int CW = intfmt_pkg::CHAR_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_PADL,
        ST_SIGN,
        ST_PRE0,
        ST_PREX,
        ST_ZPAD,
        ST_DIGS,
        ST_PADR
    } state_t;

    state_t                 state_reg, state_next;
    logic [DIG_BITS-1:0]    dig_reg, dig_next;
    logic [VW-1:0]          bin_reg, bin_next;
    logic                   ovf_reg, ovf_next;
    logic [NDIG_W-1:0]      ndig_reg, ndig_next;
    logic [FW-1:0]          cnt_reg, cnt_next;
    logic [FW-1:0]          rem_reg, rem_next;
    logic [FW-1:0]          width_reg, width_next;
    logic                   upper_reg, upper_next;
    intfmt_pkg::sign_code_t sign_reg, sign_next;
    logic [1:0]             plen_reg, plen_next;
    logic                   ladj_reg, ladj_next;
    logic                   zpad_reg, zpad_next;
    logic                   trunc_reg, trunc_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CW-1:0]          out_char_reg, out_char_next;
    logic                   out_last_reg, out_last_next;

    logic [VW-1:0]          val_ext;
    logic [DIG_BITS-1:0]    oct_digs;
    logic [DIG_BITS-1:0]    hex_digs;
    logic [DIG_BITS-1:0]    bcd_adj;
    logic                   oct_ovf;
    logic                   hex_ovf;
    logic [3:0]             top_dig;
    logic [FW-1:0]          content;
    logic                   out_free;
    logic                   emit_en;
    logic [CW-1:0]          emit_char;
    logic                   in_accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_char = out_char_reg;
    assign last = out_last_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign top_dig = dig_reg[DIG_BITS-1 -: 4];

    assign val_ext = trunc_reg ? {{(VW - 32){value[31]}}, value[31:0]} : value;

    always_comb
    begin
        oct_ovf = 1'b0;
        hex_ovf = 1'b0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            oct_digs[4*i +: 4] = {1'b0, 3'(val_ext >> (3 * i))};
            hex_digs[4*i +: 4] = 4'(val_ext >> (4 * i));
            bcd_adj[4*i +: 4] = (dig_reg[4*i +: 4] >= 4'd5) ?
                                (dig_reg[4*i +: 4] + 4'd3) : dig_reg[4*i +: 4];
        end
        for (int b = 0; b < VW; b++)
        begin
            if (b >= OCT_BITS)
            begin
                oct_ovf = oct_ovf | val_ext[b];
            end
            if (b >= HEX_BITS)
            begin
                hex_ovf = hex_ovf | val_ext[b];
            end
        end
    end

    assign content = FW'(ndig_reg) + FW'(plen_reg)
                   + ((sign_reg != intfmt_pkg::SIGN_NONE) ? FW'(1) : FW'(0));

    always_comb
    begin
        state_next = state_reg;
        dig_next = dig_reg;
        bin_next = bin_reg;
        ovf_next = ovf_reg;
        ndig_next = ndig_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        width_next = width_reg;
        upper_next = upper_reg;
        sign_next = sign_reg;
        plen_next = plen_reg;
        ladj_next = ladj_reg;
        zpad_next = zpad_reg;
        trunc_next = cfg_wen ? cfg_wdata : trunc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_char_next = out_char_reg;
        out_last_next = out_last_reg;
        emit_en = 1'b0;
        emit_char = intfmt_pkg::CH_BLANK;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    upper_next = uppercase;
                    sign_next = intfmt_pkg::sign_code_t'(sign_code);
                    ladj_next = left_adjust;
                    zpad_next = zero_pad;
                    width_next = (width > FW'(intfmt_pkg::FIELD_MAX)) ?
                                 FW'(intfmt_pkg::FIELD_MAX) : width;
                    ndig_next = NDIG_W'(MAX_DIGITS);
                    bin_next = val_ext;
                    rem_next = '0;
                    plen_next = 2'd0;
                    if (alt_form && (val_ext != '0))
                    begin
                        if (mode == intfmt_pkg::MODE_OCT)
                        begin
                            plen_next = 2'd1;
                        end
                        else if (mode != intfmt_pkg::MODE_DEC)
                        begin
                            plen_next = 2'd2;
                        end
                    end
                    if (mode == intfmt_pkg::MODE_DEC)
                    begin
                        dig_next = '0;
                        ovf_next = 1'b0;
                        cnt_next = FW'(VW - 1);
                        state_next = ST_CONV;
                    end
                    else if (mode == intfmt_pkg::MODE_OCT)
                    begin
                        dig_next = oct_digs;
                        ovf_next = oct_ovf;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        dig_next = hex_digs;
                        ovf_next = hex_ovf;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_CONV:
            begin
                dig_next = {bcd_adj[DIG_BITS-2:0], bin_reg[VW-1]};
                bin_next = {bin_reg[VW-2:0], 1'b0};
                ovf_next = ovf_reg | bcd_adj[DIG_BITS-1];
                cnt_next = cnt_reg - FW'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (ovf_reg || (ndig_reg == NDIG_W'(1)) || (top_dig != 4'd0))
                begin
                    if (width_reg > content)
                    begin
                        cnt_next = width_reg - content;
                        rem_next = width_reg;
                    end
                    else
                    begin
                        cnt_next = '0;
                        rem_next = content;
                    end
                    state_next = ST_PADL;
                end
                else
                begin
                    dig_next = {dig_reg[DIG_BITS-5:0], 4'd0};
                    ndig_next = ndig_reg - NDIG_W'(1);
                end
            end
            ST_PADL:
            begin
                if (!zpad_reg && !ladj_reg && (cnt_reg != '0))
                begin
                    if (out_free)
                    begin
                        emit_en = 1'b1;
                        emit_char = intfmt_pkg::CH_BLANK;
                        cnt_next = cnt_reg - FW'(1);
                    end
                end
                else
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                if (sign_reg != intfmt_pkg::SIGN_NONE)
                begin
                    if (out_free)
                    begin
                        emit_en = 1'b1;
                        emit_char = intfmt_pkg::sign_glyph(sign_reg);
                        state_next = ST_PRE0;
                    end
                end
                else
                begin
                    state_next = ST_PRE0;
                end
            end
            ST_PRE0:
            begin
                if (plen_reg != 2'd0)
                begin
                    if (out_free)
                    begin
                        emit_en = 1'b1;
                        emit_char = intfmt_pkg::CH_ZERO;
                        state_next = ST_PREX;
                    end
                end
                else
                begin
                    state_next = ST_PREX;
                end
            end
            ST_PREX:
            begin
                if (plen_reg == 2'd2)
                begin
                    if (out_free)
                    begin
                        emit_en = 1'b1;
                        emit_char = upper_reg ? intfmt_pkg::CH_UPPER_X : intfmt_pkg::CH_LOWER_X;
                        state_next = ST_ZPAD;
                    end
                end
                else
                begin
                    state_next = ST_ZPAD;
                end
            end
            ST_ZPAD:
            begin
                if (zpad_reg && (cnt_reg != '0))
                begin
                    if (out_free)
                    begin
                        emit_en = 1'b1;
                        emit_char = intfmt_pkg::CH_ZERO;
                        cnt_next = cnt_reg - FW'(1);
                    end
                end
                else
                begin
                    state_next = ST_DIGS;
                end
            end
            ST_DIGS:
            begin
                if (out_free)
                begin
                    emit_en = 1'b1;
                    emit_char = intfmt_pkg::digit_char(top_dig, upper_reg);
                    dig_next = {dig_reg[DIG_BITS-5:0], 4'd0};
                    ndig_next = ndig_reg - NDIG_W'(1);
                    if (ndig_reg == NDIG_W'(1))
                    begin
                        state_next = ST_PADR;
                    end
                end
            end
            ST_PADR:
            begin
                if (ladj_reg && !zpad_reg && (cnt_reg != '0))
                begin
                    if (out_free)
                    begin
                        emit_en = 1'b1;
                        emit_char = intfmt_pkg::CH_BLANK;
                        cnt_next = cnt_reg - FW'(1);
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit_en)
        begin
            out_valid_next = 1'b1;
            out_char_next = emit_char;
            out_last_next = (rem_reg == FW'(1));
            rem_next = rem_reg - FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            trunc_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            rem_reg <= '0;
            ndig_reg <= NDIG_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            trunc_reg <= trunc_next;
            out_valid_reg <= out_valid_next;
            rem_reg <= rem_next;
            ndig_reg <= ndig_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
        bin_reg <= bin_next;
        ovf_reg <= ovf_next;
        cnt_reg <= cnt_next;
        width_reg <= width_next;
        upper_reg <= upper_next;
        sign_reg <= sign_next;
        plen_reg <= plen_next;
        ladj_reg <= ladj_next;
        zpad_reg <= zpad_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    // The block never takes two items back to back.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !in_ready)
        else $error("input accepted while an item was still in work");

    // Every emitted character is one of the field's counted characters.
    a_emit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        emit_en |-> (rem_reg != '0))
        else $error("character emitted beyond the field length");

    // A field is finished only when all of its characters have been emitted.
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (rem_reg == '0))
        else $error("sequencer returned to idle with characters left");

    // The digit count never runs out before the digits are emitted.
    a_ndig_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGS) |-> (ndig_reg != '0))
        else $error("digit count reached zero while emitting digits");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam int VALUE_W = intfmt_pkg::VALUE_W;
    localparam int FIELD_W = intfmt_pkg::FIELD_W;
    localparam int CHAR_W = intfmt_pkg::CHAR_W;
    localparam int FIELD_MAX = intfmt_pkg::FIELD_MAX;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int MAX_CYCLES = 1000000;
    localparam int RANDOM_ITEMS = 128;
    localparam int RESET_CYCLES = 12;

    typedef struct packed {
        logic [VALUE_W-1:0]     value;
        logic [1:0]             mode;
        logic                   uppercase;
        intfmt_pkg::sign_code_t sign;
        logic                   alt_form;
        logic                   left_adjust;
        logic                   zero_pad;
        logic [FIELD_W-1:0]     width;
    } field_req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } field_char_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wen = 1'b0;
    logic cfg_wdata = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [VALUE_W-1:0] value = '0;
    logic [1:0] mode = intfmt_pkg::MODE_OCT;
    logic uppercase = 1'b0;
    logic [1:0] sign_code = intfmt_pkg::SIGN_NONE;
    logic alt_form = 1'b0;
    logic left_adjust = 1'b0;
    logic zero_pad = 1'b0;
    logic [FIELD_W-1:0] width = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [CHAR_W-1:0] out_char;
    logic last;

    field_char_t pending_chars[$];
    field_char_t front_char;
    logic truncate_mode = 1'b0;
    int burst_left = 0;
    int items_sent = 0;
    int chars_checked = 0;
    int config_writes = 0;
    int mismatches = 0;
    int cycle_count = 0;
    logic [9:0] stall_phase = '0;

    integer_field_formatter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .value       (value),
        .mode        (mode),
        .uppercase   (uppercase),
        .sign_code   (sign_code),
        .alt_form    (alt_form),
        .left_adjust (left_adjust),
        .zero_pad    (zero_pad),
        .width       (width),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .last        (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("Run did not complete within %0d cycles.", MAX_CYCLES);
            $display("FAILURE");
            $finish;
        end
    end

    // The receiver cycles through always-ready, random, periodic and sparse acceptance.
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 10'd1;
        case (stall_phase[9:8])
            2'd0: out_ready <= 1'b1;
            2'd1: out_ready <= 1'($urandom_range(0, 1));
            2'd2: out_ready <= (stall_phase[1:0] == 2'd3);
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_chars.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected character, expected none, actual char %h last %b",
                         $time, out_char, last);
            end
            else
            begin
                front_char = pending_chars.pop_front();
                chars_checked++;
                if (out_char !== front_char.ch)
                begin
                    mismatches++;
                    $display("%0t: out_char expected %h actual %h",
                             $time, front_char.ch, out_char);
                end
                if (last !== front_char.last)
                begin
                    mismatches++;
                    $display("%0t: last expected %b actual %b",
                             $time, front_char.last, last);
                end
            end
        end
    end

    function automatic field_req_t make_field(input logic [VALUE_W-1:0] v,
                                              input logic [1:0] m,
                                              input logic up,
                                              input intfmt_pkg::sign_code_t s,
                                              input logic alt,
                                              input logic ladj,
                                              input logic zpad,
                                              input int w);
        field_req_t r;
        r.value = v;
        r.mode = m;
        r.uppercase = up;
        r.sign = s;
        r.alt_form = alt;
        r.left_adjust = ladj;
        r.zero_pad = zpad;
        r.width = w[FIELD_W-1:0];
        return r;
    endfunction

    function automatic void format_field(input field_req_t r);
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] radix;
        logic [CHAR_W-1:0] digs [0:intfmt_pkg::DEFAULT_MAX_DIGITS-1];
        logic [CHAR_W-1:0] chars [0:FIELD_MAX-1];
        logic [CHAR_W-1:0] sign_ch;
        logic [3:0] d;
        logic has_sign;
        int ndig;
        int plen;
        int content;
        int pad;
        int fw;
        int n;
        int i;
        v = r.value;
        if (truncate_mode)
        begin
            v = {{32{v[31]}}, v[31:0]};
        end
        radix = (r.mode == intfmt_pkg::MODE_OCT) ? 64'd8 :
                (r.mode == intfmt_pkg::MODE_DEC) ? 64'd10 : 64'd16;
        fw = (r.width > FIELD_MAX) ? FIELD_MAX : int'(r.width);
        plen = 0;
        if (v != 0 && r.alt_form)
        begin
            plen = (radix == 64'd8) ? 1 : (radix == 64'd16) ? 2 : 0;
        end
        has_sign = (r.sign != intfmt_pkg::SIGN_NONE);
        case (r.sign)
            intfmt_pkg::SIGN_PLUS:  sign_ch = intfmt_pkg::CH_PLUS;
            intfmt_pkg::SIGN_BLANK: sign_ch = intfmt_pkg::CH_BLANK;
            default:                sign_ch = intfmt_pkg::CH_MINUS;
        endcase
        ndig = 0;
        do
        begin
            d = 4'(v % radix);
            if (d < 4'd10)
            begin
                digs[ndig] = intfmt_pkg::CH_ZERO + {3'd0, d};
            end
            else
            begin
                digs[ndig] = (r.uppercase ? intfmt_pkg::CH_UPPER_A : intfmt_pkg::CH_LOWER_A)
                             + {3'd0, d} - 7'd10;
            end
            ndig++;
            v = v / radix;
        end
        while (v != 0 && ndig < intfmt_pkg::DEFAULT_MAX_DIGITS);
        content = ndig + plen + (has_sign ? 1 : 0);
        pad = (fw > content) ? fw - content : 0;
        n = 0;
        if (!r.zero_pad && !r.left_adjust)
        begin
            for (i = 0; i < pad; i++)
            begin
                chars[n] = intfmt_pkg::CH_BLANK;
                n++;
            end
        end
        if (has_sign)
        begin
            chars[n] = sign_ch;
            n++;
        end
        if (plen >= 1)
        begin
            chars[n] = intfmt_pkg::CH_ZERO;
            n++;
        end
        if (plen == 2)
        begin
            chars[n] = r.uppercase ? intfmt_pkg::CH_UPPER_X : intfmt_pkg::CH_LOWER_X;
            n++;
        end
        if (r.zero_pad)
        begin
            for (i = 0; i < pad; i++)
            begin
                chars[n] = intfmt_pkg::CH_ZERO;
                n++;
            end
        end
        for (i = ndig; i > 0; i--)
        begin
            chars[n] = digs[i-1];
            n++;
        end
        if (r.left_adjust && !r.zero_pad)
        begin
            for (i = 0; i < pad; i++)
            begin
                chars[n] = intfmt_pkg::CH_BLANK;
                n++;
            end
        end
        for (i = 0; i < n; i++)
        begin
            pending_chars.push_back(field_char_t'({chars[i], (i == n - 1)}));
        end
    endfunction

    task automatic send_item(input field_req_t r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        value <= r.value;
        mode <= r.mode;
        uppercase <= r.uppercase;
        sign_code <= r.sign;
        alt_form <= r.alt_form;
        left_adjust <= r.left_adjust;
        zero_pad <= r.zero_pad;
        width <= r.width;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        format_field(r);
        items_sent++;
    endtask

    task automatic drain_fields();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_truncate(input logic on);
        drain_fields();
        cfg_wen <= 1'b1;
        cfg_wdata <= on;
        @(posedge clk);
        cfg_wen <= 1'b0;
        truncate_mode = on;
        config_writes++;
    endtask

    task automatic test_extremes();
        set_truncate(1'b0);
        send_item(make_field('0, intfmt_pkg::MODE_OCT, 1'b0, intfmt_pkg::SIGN_NONE,
                             1'b0, 1'b0, 1'b0, 0));
        send_item(make_field('1, intfmt_pkg::MODE_OCT, 1'b0, intfmt_pkg::SIGN_NONE,
                             1'b0, 1'b0, 1'b0, 0));
        send_item(make_field('0, intfmt_pkg::MODE_DEC, 1'b0, intfmt_pkg::SIGN_NONE,
                             1'b0, 1'b0, 1'b0, 0));
        send_item(make_field('1, intfmt_pkg::MODE_DEC, 1'b0, intfmt_pkg::SIGN_NONE,
                             1'b0, 1'b0, 1'b0, 0));
        send_item(make_field('0, intfmt_pkg::MODE_HEX, 1'b0, intfmt_pkg::SIGN_NONE,
                             1'b0, 1'b0, 1'b0, 0));
        send_item(make_field('1, intfmt_pkg::MODE_HEX, 1'b1, intfmt_pkg::SIGN_NONE,
                             1'b0, 1'b0, 1'b0, 0));
        send_item(make_field('1, intfmt_pkg::MODE_OCT, 1'b0, intfmt_pkg::SIGN_PLUS,
                             1'b1, 1'b0, 1'b1, FIELD_MAX));
        send_item(make_field(64'd1, intfmt_pkg::MODE_DEC, 1'b0, intfmt_pkg::SIGN_NONE,
                             1'b0, 1'b0, 1'b0, 127));
        send_item(make_field(64'd1, intfmt_pkg::MODE_HEX, 1'b0, intfmt_pkg::SIGN_MINUS,
                             1'b1, 1'b1, 1'b0, FIELD_MAX));
    endtask

    task automatic test_flags();
        send_item(make_field(64'hBEEF, MODE_SPARE, 1'b1, intfmt_pkg::SIGN_NONE,
                             1'b1, 1'b0, 1'b0, 8));
        send_item(make_field(64'd77, intfmt_pkg::MODE_DEC, 1'b0, intfmt_pkg::SIGN_PLUS,
                             1'b0, 1'b1, 1'b1, 10));
        send_item(make_field(64'hCAFE, intfmt_pkg::MODE_HEX, 1'b1, intfmt_pkg::SIGN_NONE,
                             1'b1, 1'b0, 1'b0, 0));
        send_item(make_field('0, intfmt_pkg::MODE_OCT, 1'b0, intfmt_pkg::SIGN_NONE,
                             1'b1, 1'b0, 1'b0, 0));
        send_item(make_field('0, intfmt_pkg::MODE_HEX, 1'b0, intfmt_pkg::SIGN_NONE,
                             1'b1, 1'b0, 1'b1, 5));
        send_item(make_field(64'd42, intfmt_pkg::MODE_DEC, 1'b0, intfmt_pkg::SIGN_NONE,
                             1'b0, 1'b0, 1'b0, 6));
        send_item(make_field(64'd42, intfmt_pkg::MODE_DEC, 1'b0, intfmt_pkg::SIGN_PLUS,
                             1'b0, 1'b0, 1'b0, 6));
        send_item(make_field(64'd42, intfmt_pkg::MODE_DEC, 1'b0, intfmt_pkg::SIGN_BLANK,
                             1'b0, 1'b1, 1'b0, 6));
        send_item(make_field(64'd42, intfmt_pkg::MODE_DEC, 1'b0, intfmt_pkg::SIGN_MINUS,
                             1'b0, 1'b0, 1'b1, 6));
        send_item(make_field(64'd12345678901234567890, intfmt_pkg::MODE_DEC, 1'b0,
                             intfmt_pkg::SIGN_MINUS, 1'b0, 1'b0, 1'b0, 3));
        send_item(make_field(64'd99, intfmt_pkg::MODE_DEC, 1'b0, intfmt_pkg::SIGN_NONE,
                             1'b1, 1'b0, 1'b0, 4));
        send_item(make_field(64'o755, intfmt_pkg::MODE_OCT, 1'b0, intfmt_pkg::SIGN_NONE,
                             1'b1, 1'b1, 1'b0, 9));
    endtask

    task automatic test_truncate();
        set_truncate(1'b1);
        send_item(make_field(64'h0000_0000_8000_0000, intfmt_pkg::MODE_DEC, 1'b0,
                             intfmt_pkg::SIGN_NONE, 1'b0, 1'b0, 1'b0, 0));
        send_item(make_field(64'hFFFF_FFFF_7FFF_FFFF, intfmt_pkg::MODE_HEX, 1'b0,
                             intfmt_pkg::SIGN_NONE, 1'b1, 1'b0, 1'b0, 12));
        send_item(make_field(64'h1234_5678_FFFF_FFFF, intfmt_pkg::MODE_OCT, 1'b0,
                             intfmt_pkg::SIGN_PLUS, 1'b1, 1'b0, 1'b1, 30));
        set_truncate(1'b0);
    endtask

    task automatic test_random();
        field_req_t r;
        int phase;
        int k;
        for (phase = 0; phase < 4; phase++)
        begin
            set_truncate(phase[0]);
            for (k = 0; k < RANDOM_ITEMS / 4; k++)
            begin
                case ($urandom_range(0, 5))
                    0: r.value = {$urandom, $urandom};
                    1: r.value = VALUE_W'($urandom_range(0, 20));
                    2: r.value = {$urandom, $urandom | 32'h8000_0000};
                    3:
                    begin
                        case ($urandom_range(0, 2))
                            0: r.value = '0;
                            1: r.value = '1;
                            default: r.value = 64'h8000_0000_0000_0000;
                        endcase
                    end
                    4: r.value = {32'h0, $urandom};
                    default: r.value = {$urandom, $urandom} >> $urandom_range(0, 63);
                endcase
                r.mode = 2'($urandom_range(0, 3));
                r.uppercase = 1'($urandom_range(0, 1));
                r.sign = intfmt_pkg::sign_code_t'($urandom_range(0, 3));
                r.alt_form = 1'($urandom_range(0, 1));
                r.left_adjust = 1'($urandom_range(0, 1));
                r.zero_pad = 1'($urandom_range(0, 1));
                r.width = ($urandom_range(0, 4) == 0) ? FIELD_W'($urandom_range(0, 127))
                                                      : FIELD_W'($urandom_range(0, 24));
                send_item(r);
            end
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_flags();
        test_truncate();
        test_random();
        drain_fields();
        repeat (40) @(posedge clk);
        $display("Formatted %0d fields in octal, decimal and hex with all padding flags,",
                 items_sent);
        $display("checking %0d characters over %0d truncate-mode writes.",
                 chars_checked, config_writes);
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
